FILE: hdl/ray_value_crossing_finder_assert.svh
// Assertion macros used by the checker of the crossing finder.
`ifndef RAY_VALUE_CROSSING_FINDER_ASSERT_SVH
`define RAY_VALUE_CROSSING_FINDER_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define RVCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define RVCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rvcf_pkg.sv
`default_nettype none

package rvcf_pkg;

	localparam int VAL_W  = 32;
	localparam int DIST_W = 26;
	localparam int LOC_W  = 10;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [LOC_W-1:0] loc_t;

	// Handshake between the job queue and its neighbours.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

FILE: hdl/rvcf_front.sv
`default_nettype none

module rvcf_front #(
	parameter int MAX_SAMPLES = 1024,
	parameter int IDX_W       = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  rvcf_pkg::value_t                      critical_value,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  rvcf_pkg::value_t                      sample_value,
	input  logic                                  sample_valid,
	input  logic                                  end_of_ray,
	input  rvcf_pkg::queue_status_t               queue_status,
	output logic                                  job_push,
	output logic [IDX_W+2*rvcf_pkg::VAL_W+1:0]    job_data
);
	import rvcf_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	value_t             cv_q;
	value_t             prev_q;
	logic               prev_valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               found_q;
	logic               eq_q;
	logic [IDX_W-1:0]   idx_q;
	logic [VAL_W-1:0]   num_q;
	logic [VAL_W-1:0]   den_q;

	logic               accept;
	logic               examine;
	logic               is_eq;
	logic               rise;
	logic               fall;
	logic               new_hit;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   idx_new;
	logic signed [VAL_W:0] prev_x;
	logic signed [VAL_W:0] cv_x;
	logic signed [VAL_W:0] cur_x;
	logic signed [VAL_W:0] num_x;
	logic signed [VAL_W:0] den_x;

	assign cfg_ready = 1'b1;
	assign in_ready  = !queue_status.full;
	assign accept    = in_valid && in_ready;
	assign job_push  = accept && end_of_ray;

	// A pair is looked at only while no hit is held and both indexes lie below the limit.
	assign examine = !found_q && prev_valid_q && (cnt_q != '0)
		&& (cnt_q < CNT_W'(MAX_SAMPLES));
	assign is_eq   = (prev_q == cv_q);
	assign rise    = (prev_q < cv_q) && (cv_q < sample_value);
	assign fall    = (prev_q > cv_q) && (cv_q > sample_value);
	assign new_hit = examine && (is_eq || (sample_valid && (rise || fall)));

	assign cnt_m1  = cnt_q - 1'b1;
	assign idx_new = cnt_m1[IDX_W-1:0];

	assign prev_x = {prev_q[VAL_W-1], prev_q};
	assign cv_x   = {cv_q[VAL_W-1], cv_q};
	assign cur_x  = {sample_value[VAL_W-1], sample_value};
	assign num_x  = rise ? (cv_x - prev_x) : (prev_x - cv_x);
	assign den_x  = rise ? (cur_x - prev_x) : (prev_x - cur_x);

	always_comb begin
		if (found_q) begin
			job_data = {1'b1, eq_q, idx_q, num_q, den_q};
		end else if (new_hit) begin
			job_data = {1'b1, is_eq, idx_new, num_x[VAL_W-1:0], den_x[VAL_W-1:0]};
		end else begin
			job_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cv_q <= critical_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
		end else if (accept) begin
			if (end_of_ray) begin
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
				cnt_q        <= '0;
				found_q      <= 1'b0;
			end else begin
				prev_q       <= sample_value;
				prev_valid_q <= sample_valid;
				if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (new_hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && new_hit) begin
			eq_q  <= is_eq;
			idx_q <= idx_new;
			num_q <= num_x[VAL_W-1:0];
			den_q <= den_x[VAL_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rvcf_fifo.sv
`default_nettype none

module rvcf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic [WIDTH-1:0]        push_data,
	input  logic                    pop,
	output logic [WIDTH-1:0]        head_data,
	output rvcf_pkg::queue_status_t status
);
	import rvcf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_data    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rvcf_back.sv
`default_nettype none

module rvcf_back #(
	parameter int FRACTION_BITS = 16,
	parameter int IDX_W         = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rvcf_pkg::queue_status_t               queue_status,
	input  logic [IDX_W+2*rvcf_pkg::VAL_W+1:0]    job_data,
	output logic                                  job_pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  hit,
	output rvcf_pkg::dist_t                       hit_distance,
	output rvcf_pkg::loc_t                        hit_location
);
	import rvcf_pkg::*;

	localparam int STEP_W = $clog2(FRACTION_BITS + 1);
	localparam int SUM_W  = IDX_W + FRACTION_BITS + 1;
	localparam int WIDE_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
	localparam int LSUM_W = (IDX_W + 1 > LOC_W) ? IDX_W + 1 : LOC_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]               state_q;
	logic [STEP_W-1:0]        step_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         idx_q;
	logic [VAL_W-1:0]         rem_q;
	logic [VAL_W-1:0]         den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic                     round_q;
	dist_t                    dist_q;
	loc_t                     loc_q;

	logic                     j_hit;
	logic                     j_eq;
	logic [IDX_W-1:0]         j_idx;
	logic [VAL_W-1:0]         j_num;
	logic [VAL_W-1:0]         j_den;
	logic                     j_div;
	logic [VAL_W:0]           rem_dbl;
	logic [VAL_W:0]           rem_sub;
	logic                     rem_ge;
	logic [WIDE_W-1:0]        dist_sum;
	logic [LSUM_W-1:0]        loc_sum;

	assign {j_hit, j_eq, j_idx, j_num, j_den} = job_data;
	assign j_div   = j_hit && !j_eq;
	assign job_pop = (state_q == ST_IDLE) && !queue_status.empty;

	// Restoring division: one quotient bit of num * 2^FRACTION_BITS / den per cycle.
	assign rem_dbl = {rem_q, 1'b0};
	assign rem_sub = rem_dbl - {1'b0, den_q};
	assign rem_ge  = (rem_dbl >= {1'b0, den_q});

	assign dist_sum = (WIDE_W'(idx_q) << FRACTION_BITS) + WIDE_W'(quo_q);
	assign loc_sum  = LSUM_W'(idx_q) + LSUM_W'(round_q);

	assign out_valid    = (state_q == ST_OUT);
	assign hit          = hit_q;
	assign hit_distance = dist_q;
	assign hit_location = loc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!queue_status.empty) begin
						hit_q   <= j_hit;
						step_q  <= STEP_W'(FRACTION_BITS);
						state_q <= j_div ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q   <= j_idx;
				rem_q   <= j_num;
				den_q   <= j_den;
				quo_q   <= '0;
				round_q <= j_div && ({j_num, 1'b0} > {1'b0, j_den});
			end
			ST_DIV: begin
				rem_q <= rem_ge ? rem_sub[VAL_W-1:0] : rem_dbl[VAL_W-1:0];
				quo_q <= {quo_q[FRACTION_BITS-2:0], rem_ge};
			end
			ST_FIN: begin
				dist_q <= hit_q ? dist_sum[DIST_W-1:0] : '0;
				loc_q  <= hit_q ? loc_sum[LOC_W-1:0] : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/ray_value_crossing_finder.sv
// Finds the first place along a ray where the samples meet critical_value. Samples are
// taken one per cycle; the beat flagged end_of_ray closes the ray and yields one result
// beat, with hit_distance as the sample index shifted up by FRACTION_BITS plus the
// interpolated fraction. The front end classifies sample pairs at full rate and hands each
// finished ray to a two-entry queue; the back end works out the fraction with a restoring
// divider that produces one quotient bit per cycle and takes the next ray from the queue
// only once the result beat of the last ray has been taken. Input beats stall only while
// the queue is full, i.e. when rays arrive faster than the back end takes them.
// No clearing pass is needed after reset.
`default_nettype none

module ray_value_crossing_finder #(
	parameter int MAX_SAMPLES   = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  rvcf_pkg::value_t  critical_value,
	input  logic              in_valid,
	output logic              in_ready,
	input  rvcf_pkg::value_t  sample_value,
	input  logic              sample_valid,
	input  logic              end_of_ray,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output rvcf_pkg::dist_t   hit_distance,
	output rvcf_pkg::loc_t    hit_location
);
	import rvcf_pkg::*;

	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int JOB_W       = IDX_W + 2 * VAL_W + 2;
	localparam int QUEUE_DEPTH = 2;

	queue_status_t    queue_status;
	logic             job_push;
	logic             job_pop;
	logic [JOB_W-1:0] push_job;
	logic [JOB_W-1:0] head_job;

	rvcf_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.IDX_W       (IDX_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.critical_value (critical_value),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_value   (sample_value),
		.sample_valid   (sample_valid),
		.end_of_ray     (end_of_ray),
		.queue_status   (queue_status),
		.job_push       (job_push),
		.job_data       (push_job)
	);

	rvcf_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (push_job),
		.pop       (job_pop),
		.head_data (head_job),
		.status    (queue_status)
	);

	rvcf_back #(
		.FRACTION_BITS (FRACTION_BITS),
		.IDX_W         (IDX_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_status (queue_status),
		.job_data     (head_job),
		.job_pop      (job_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.hit_distance (hit_distance),
		.hit_location (hit_location)
	);

endmodule

`default_nettype wire

FILE: hdl/rvcf_checker.sv
`default_nettype none

`include "ray_value_crossing_finder_assert.svh"

module rvcf_checker #(
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             hit,
	input  rvcf_pkg::dist_t  hit_distance,
	input  rvcf_pkg::loc_t   hit_location
);
	import rvcf_pkg::*;

	// Location bits that still show in the masked distance.
	localparam int SHOWN_W = (DIST_W - FRACTION_BITS < LOC_W) ? DIST_W - FRACTION_BITS : LOC_W;

	`RVCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(hit_distance) && $stable(hit_location), "result beat changed while stalled")

	`RVCF_ASSERT_NOW(a_miss_zero, out_valid && !hit, hit_distance == '0 && hit_location == '0, "miss reported with non-zero distance or location")

	// A fraction below one half can never round the location up.
	`RVCF_ASSERT_NOW(a_loc_low_frac, out_valid && hit && !hit_distance[FRACTION_BITS-1], hit_location[SHOWN_W-1:0] == hit_distance[FRACTION_BITS+SHOWN_W-1:FRACTION_BITS], "location disagrees with distance")

endmodule

bind ray_value_crossing_finder rvcf_checker #(.FRACTION_BITS(FRACTION_BITS)) u_rvcf_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import rvcf_pkg::*;

	localparam int RAY_MAX   = 1024;
	localparam int FRAC_BITS = 16;
	// Time for the back end to finish its last ray; allow a good margin.
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic  hit;
		dist_t distance;
		loc_t  loc;
	} ray_hit_t;

	class crossing_tracker;
		value_t      crit;
		value_t      last_value;
		bit          last_valid;
		int unsigned next_index;
		bit          found;
		dist_t       found_dist;
		loc_t        found_loc;
		ray_hit_t    awaited_hits[$];
		int unsigned wrong_count;

		function new();
			crit = '0;
			wrong_count = 0;
			clear_ray();
		endfunction

		function void clear_ray();
			last_value = '0;
			last_valid = 1'b0;
			next_index = 0;
			found = 1'b0;
			found_dist = '0;
			found_loc = '0;
		endfunction

		function void set_critical(value_t v);
			crit = v;
		endfunction

		function int pending();
			return awaited_hits.size();
		endfunction

		// Called for every accepted sample beat.
		function void note_sample(value_t v, bit valid, bit last);
			longint p, c, k, num, den, q;
			int unsigned i;
			ray_hit_t res;
			if (!found && last_valid && next_index >= 1 && next_index < RAY_MAX) begin
				i = next_index - 1;
				p = longint'(last_value);
				c = longint'(v);
				k = longint'(crit);
				if (p == k) begin
					found = 1'b1;
					found_dist = dist_t'(longint'(i) << FRAC_BITS);
					found_loc = loc_t'(i);
				end else if (valid && ((p < k && k < c) || (p > k && k > c))) begin
					num = (p < k) ? k - p : p - k;
					den = (p < k) ? c - p : p - c;
					q = (num << FRAC_BITS) / den;
					found = 1'b1;
					found_dist = dist_t'((longint'(i) << FRAC_BITS) + q);
					found_loc = loc_t'((2 * num > den) ? i + 1 : i);
				end
			end
			last_value = v;
			last_valid = valid;
			if (next_index < RAY_MAX)
				next_index++;
			if (last) begin
				res.hit = found;
				res.distance = found ? found_dist : '0;
				res.loc = found ? found_loc : '0;
				awaited_hits.push_back(res);
				clear_ray();
			end
		endfunction

		function void check_hit(logic h, dist_t d, loc_t l);
			ray_hit_t want;
			if (awaited_hits.size() == 0) begin
				wrong_count++;
				if (wrong_count <= 10)
					$display("result with no ray pending: hit=%0b dist=%h loc=%0d", h, d, l);
				return;
			end
			want = awaited_hits.pop_front();
			if (want.hit !== h || want.distance !== d || want.loc !== l) begin
				wrong_count++;
				if (wrong_count <= 10)
					$display("wrong result: expected hit=%0b dist=%h loc=%0d, got hit=%0b dist=%h loc=%0d",
						want.hit, want.distance, want.loc, h, d, l);
			end
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	value_t critical_value = '0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	value_t sample_value = '0;
	logic   sample_valid = 1'b0;
	logic   end_of_ray = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	logic   hit;
	dist_t  hit_distance;
	loc_t   hit_location;

	crossing_tracker book = new();
	value_t crit_now = '0;
	int     send_idle_pct = 0;
	int     stall_pct = 0;
	int     hold_req = 0;
	int     hold_taken = 0;
	int     hold_left = 0;

	ray_value_crossing_finder #(
		.MAX_SAMPLES(RAY_MAX),
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.critical_value(critical_value),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_value(sample_value),
		.sample_valid(sample_valid),
		.end_of_ray(end_of_ray),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.hit_distance(hit_distance),
		.hit_location(hit_location)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_req != hold_taken) begin
			hold_taken = hold_req;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_hit(hit, hit_distance, hit_location);
	end

	// Entered and left at a falling edge.
	task automatic send_beat(value_t v, bit valid, bit last);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= v;
		sample_valid <= valid;
		end_of_ray <= last;
		do
			@(posedge clk);
		while (!in_ready);
		book.note_sample(v, valid, last);
		@(negedge clk);
	endtask

	task automatic pair_ray(value_t a, bit av, value_t b, bit bv);
		send_beat(a, av, 1'b0);
		send_beat(b, bv, 1'b1);
	endtask

	task automatic wait_drained();
		while (book.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_critical(value_t v);
		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		critical_value <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		book.set_critical(v);
		crit_now = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic value_t near_critical(int side);
		longint d, x;
		if ($urandom_range(11) == 0)
			return crit_now;
		d = longint'($urandom >> $urandom_range(31)) + 1;
		x = longint'(crit_now) + side * d;
		if (x > 64'sh7FFFFFFF)
			x = 64'sh7FFFFFFF;
		if (x < -64'sh80000000)
			x = -64'sh80000000;
		return value_t'(x);
	endfunction

	// Mostly rays that wander across the critical value, with some pure noise rays.
	task automatic run_rays(int n_items, int max_len);
		int sent, len, side;
		bit noise;
		value_t v;
		bit valid;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(max_len, 2);
			noise = ($urandom_range(7) == 0);
			side = $urandom_range(1) ? 1 : -1;
			for (int k = 0; k < len; k++) begin
				if (noise) begin
					v = value_t'($urandom);
					valid = $urandom_range(1);
				end else begin
					if ($urandom_range(3) == 0)
						side = -side;
					v = near_critical(side);
					valid = ($urandom_range(9) != 0);
				end
				send_beat(v, valid, k == len - 1);
				sent++;
			end
		end
	endtask

	// Only the pair starting at cross_at straddles the value; past the counter
	// limit that pair must be ignored.
	task automatic long_ray(int cross_at, int len);
		longint x;
		for (int k = 0; k < len; k++) begin
			x = longint'(crit_now) + ((k <= cross_at) ? -1 : 1) * longint'($urandom_range(4096, 1));
			send_beat(value_t'(x), 1'b1, k == len - 1);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rays against the reset value of zero.
		send_beat(32'sh0, 1'b1, 1'b1);
		pair_ray(32'sh10000, 1'b1, 32'sh0, 1'b1);
		pair_ray(32'sh0, 1'b1, 32'sh50000, 1'b1);
		pair_ray(32'sh0, 1'b1, 32'sh50000, 1'b0);
		pair_ray(-32'sh10000, 1'b1, 32'sh30000, 1'b1);
		pair_ray(-32'sh30000, 1'b1, 32'sh10000, 1'b1);
		pair_ray(32'sh7FFFFFFF, 1'b1, 32'sh80000000, 1'b1);
		pair_ray(-32'sh1, 1'b1, 32'sh1, 1'b1);
		pair_ray(-32'sh5, 1'b1, 32'sh5, 1'b0);
		pair_ray(-32'sh5, 1'b0, 32'sh5, 1'b1);
		pair_ray(32'sh0, 1'b0, 32'sh7, 1'b1);
		send_beat(-32'sh1, 1'b1, 1'b0);
		send_beat(32'sh1, 1'b1, 1'b0);
		send_beat(-32'sh1, 1'b1, 1'b0);
		send_beat(32'sh1, 1'b1, 1'b1);

		write_critical(value_t'($urandom));
		run_rays(250, 12);

		write_critical(32'sh7FFFFFFF);
		send_idle_pct = 87;
		run_rays(150, 8);

		write_critical(32'sh80000000);
		send_idle_pct = 0;
		stall_pct = 87;
		run_rays(150, 8);

		write_critical(value_t'($signed($urandom) >>> 11));
		send_idle_pct = 6;
		stall_pct = 6;
		long_ray(1023, 1026);
		run_rays(150, 40);

		// Hold the result side off while short rays keep coming, so the queue fills.
		write_critical(value_t'($urandom));
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = hold_req + 1;
		run_rays(150, 3);

		write_critical(value_t'($urandom));
		send_idle_pct = 6;
		stall_pct = 6;
		run_rays(100, 20);

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.wrong_count == 0 && book.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
